### hdl/bm_pkg.sv
package bm_pkg;

  localparam int FRACTION_BITS_DEF = 32;
  localparam int EPS_SHIFT = 26;

  typedef logic signed [63:0] fix_t;

  localparam fix_t FIX_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam fix_t FIX_MIN = 64'sh8000_0000_0000_0000;
  // (3 - sqrt(5)) / 2 as unsigned Q0.64; it is below one half, so it also reads as positive.
  localparam fix_t GOLDEN_Q64 = 64'sd7046029254386353130;
  // floor(2^64 / 3) as unsigned Q0.64, used to form tol/3 on the shared multiplier.
  localparam fix_t THIRD_Q64 = 64'sh5555_5555_5555_5555;

  typedef enum logic [1:0] {
    ST_PROBE   = 2'd0,
    ST_DONE    = 2'd1,
    ST_IGNORED = 2'd2
  } status_e;

  typedef enum logic {
    MODE_START = 1'b0,
    MODE_VALUE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_FIRST = 2'd1,
    PH_PROBE = 2'd2
  } phase_e;

  typedef enum logic [1:0] {
    REG_LOWER = 2'd0,
    REG_UPPER = 2'd1,
    REG_TOL   = 2'd2
  } reg_idx_e;

  typedef enum logic [4:0] {
    CS_IDLE, CS_ST_MUL, CS_ST_ADD, CS_ST_TOL, CS_UPDATE,
    CS_IT_MID, CS_IT_T2, CS_IT_TEST,
    CS_PA_R, CS_PA_Q, CS_PA_T1, CS_PA_T2, CS_PA_PQ, CS_PA_DBL, CS_PA_SIGN, CS_PA_QCHK,
    CS_CK_QR, CS_CK_QR_CMP, CS_CK_QA, CS_CK_QB,
    CS_DIV, CS_DIV_U, CS_DIV_CHK, CS_GOLD_E, CS_GOLD_MUL, CS_FINAL, CS_OUT
  } core_state_e;

  typedef struct packed {
    logic       mode;
    fix_t       function_value;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    fix_t       point;
  } out_item_t;

  typedef struct packed {
    logic start;
    logic full_shift;
    fix_t a;
    fix_t b;
  } mul_req_t;

  typedef struct packed {
    logic start;
    fix_t p;
    fix_t q;
  } div_req_t;

  typedef struct packed {
    logic done;
    fix_t value;
  } unit_rsp_t;

  function automatic fix_t sadd(fix_t a, fix_t b);
    fix_t s;
    s = a + b;
    if (a[63] == b[63] && s[63] != a[63]) return a[63] ? FIX_MIN : FIX_MAX;
    return s;
  endfunction

  function automatic fix_t ssub(fix_t a, fix_t b);
    fix_t s;
    s = a - b;
    if (a[63] != b[63] && s[63] != a[63]) return a[63] ? FIX_MIN : FIX_MAX;
    return s;
  endfunction

  function automatic fix_t sneg(fix_t a);
    return (a == FIX_MIN) ? FIX_MAX : -a;
  endfunction

  function automatic fix_t sabs(fix_t a);
    return a[63] ? sneg(a) : a;
  endfunction

  function automatic logic [63:0] mag(fix_t a);
    return a[63] ? 64'(64'd0 - 64'(a)) : 64'(a);
  endfunction

  function automatic fix_t from_mag(logic neg, logic ovf, logic [63:0] m);
    if (!neg) return (ovf || m[63]) ? FIX_MAX : fix_t'(m);
    if (ovf || m[63]) return FIX_MIN;
    return -fix_t'(m);
  endfunction

  function automatic fix_t midpoint(fix_t a, fix_t b);
    return (a >>> 1) + (b >>> 1) + fix_t'({63'd0, a[0] & b[0]});
  endfunction

endpackage

### hdl/bm_mul.sv
module bm_mul #(
  parameter int FRACTION_BITS = bm_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bm_pkg::mul_req_t  req_i,
  output bm_pkg::unit_rsp_t rsp_o
);
  import bm_pkg::*;

  localparam logic [127:0] HalfFrac = 128'd1 << (FRACTION_BITS - 1);
  localparam logic [127:0] HalfFull = 128'd1 << 63;

  logic         busy_q, done_q;
  logic [2:0]   cnt_q;
  logic [63:0]  xm_q, ym_q, prod_q;
  logic [1:0]   pidx_q;
  logic         neg_q, full_q;
  logic [127:0] acc_q, prod_sh;
  fix_t         res_q;
  logic [31:0]  xsel, ysel;
  logic [63:0]  pp, m;
  logic         ovf;

  // Four 32x32 partial products, one per cycle, then rounding and saturation.
  assign xsel = cnt_q[0] ? xm_q[63:32] : xm_q[31:0];
  assign ysel = cnt_q[1] ? ym_q[63:32] : ym_q[31:0];
  assign pp   = 64'(xsel) * 64'(ysel);

  always_comb begin
    case (pidx_q)
      2'd0:    prod_sh = {64'd0, prod_q};
      2'd3:    prod_sh = {prod_q, 64'd0};
      default: prod_sh = {32'd0, prod_q, 32'd0};
    endcase
    if (full_q) begin
      m   = acc_q[127:64];
      ovf = 1'b0;
    end else begin
      m   = acc_q[FRACTION_BITS +: 64];
      ovf = |acc_q[127:FRACTION_BITS+64];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd6);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd6) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      xm_q   <= mag(req_i.a);
      ym_q   <= mag(req_i.b);
      neg_q  <= req_i.a[63] ^ req_i.b[63];
      full_q <= req_i.full_shift;
      acc_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q <= 3'd3) begin
        prod_q <= pp;
        pidx_q <= cnt_q[1:0];
      end
      if (cnt_q >= 3'd1 && cnt_q <= 3'd4) acc_q <= acc_q + prod_sh;
      if (cnt_q == 3'd5) acc_q <= acc_q + (full_q ? HalfFull : HalfFrac);
      if (cnt_q == 3'd6) res_q <= from_mag(neg_q, ovf, m);
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

endmodule

### hdl/bm_div.sv
module bm_div #(
  parameter int FRACTION_BITS = bm_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bm_pkg::div_req_t  req_i,
  output bm_pkg::unit_rsp_t rsp_o
);
  import bm_pkg::*;

  logic        busy_q, done_q;
  logic [6:0]  cnt_q;
  logic [63:0] rem_q, lo_q, dvs_q, quot_q, pm;
  logic        neg_q, sat_q;
  logic [64:0] r65, diff;
  fix_t        res_q;

  assign pm   = mag(req_i.p);
  assign r65  = {rem_q, lo_q[63]};
  assign diff = r65 - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd64);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd64) busy_q <= 1'b0;
      end
    end
  end

  // Restoring division, one quotient bit per cycle over a 128-bit dividend.
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      dvs_q  <= 64'(req_i.q);
      quot_q <= '0;
      rem_q  <= pm >> (64 - FRACTION_BITS);
      lo_q   <= pm << FRACTION_BITS;
      neg_q  <= req_i.p[63];
      sat_q  <= (pm >> (64 - FRACTION_BITS)) >= 64'(req_i.q);
    end else if (busy_q) begin
      if (cnt_q < 7'd64) begin
        lo_q <= lo_q << 1;
        if (!diff[64]) begin
          rem_q  <= diff[63:0];
          quot_q <= {quot_q[62:0], 1'b1};
        end else begin
          rem_q  <= r65[63:0];
          quot_q <= {quot_q[62:0], 1'b0};
        end
      end else begin
        res_q <= from_mag(neg_q, sat_q, sat_q ? 64'd0 : quot_q);
      end
    end
  end

  assign rsp_o.done  = done_q;
  assign rsp_o.value = res_q;

endmodule

### hdl/bm_core.sv
module bm_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bm_pkg::fix_t      lower_i,
  input  bm_pkg::fix_t      upper_i,
  input  logic [62:0]       tol_i,
  input  logic              take_i,
  input  bm_pkg::in_item_t  item_i,
  output logic              idle_o,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output bm_pkg::out_item_t res_o,
  output bm_pkg::mul_req_t  mul_req_o,
  input  bm_pkg::unit_rsp_t mul_rsp_i,
  output bm_pkg::div_req_t  div_req_o,
  input  bm_pkg::unit_rsp_t div_rsp_i
);
  import bm_pkg::*;

  core_state_e st_q, st_d;
  phase_e      phase_q, phase_d;
  logic        issued_q, issued_d;

  fix_t a_q, b_q, x_q, w_q, v_q, fx_q, fw_q, fv_q;
  fix_t e_q, dlast_q, probe_q, tol3_q, fu_q;
  fix_t xm_q, tol1_q, t2_q, p_q, q_q, r_q, d_q, tmp_q, u_q;
  logic [1:0] res_status_q;
  fix_t       res_point_q;

  fix_t x_new, final_u, lim;
  logic done_cond, near_edge;

  assign x_new = sadd(a_q, tmp_q);
  assign lim   = ssub(t2_q, u_q);
  assign done_cond = tmp_q <= lim;
  assign near_edge = (ssub(u_q, a_q) < t2_q) || (ssub(b_q, u_q) < t2_q);

  always_comb begin
    if (sabs(d_q) >= tol1_q) final_u = sadd(x_q, d_q);
    else if (d_q > 0)        final_u = sadd(x_q, tol1_q);
    else                     final_u = ssub(x_q, tol1_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= CS_IDLE;
      phase_q  <= PH_IDLE;
      issued_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      phase_q  <= phase_d;
      issued_q <= issued_d;
    end
  end

  always_comb begin
    st_d      = st_q;
    phase_d   = phase_q;
    issued_d  = issued_q;
    mul_req_o = '0;
    div_req_o = '0;
    case (st_q)
      CS_IDLE: begin
        if (take_i) begin
          if (item_i.mode == MODE_START) begin
            st_d    = CS_ST_MUL;
            phase_d = PH_FIRST;
          end else begin
            case (phase_q)
              PH_FIRST: st_d = CS_IT_MID;
              PH_PROBE: st_d = CS_UPDATE;
              default:  st_d = CS_OUT;
            endcase
          end
        end
      end
      CS_ST_MUL, CS_ST_TOL, CS_PA_R, CS_PA_Q, CS_PA_T1, CS_PA_T2,
      CS_CK_QR, CS_CK_QA, CS_CK_QB, CS_GOLD_MUL: begin
        mul_req_o.start = !issued_q;
        case (st_q)
          CS_ST_MUL: begin
            mul_req_o.a = ssub(b_q, a_q);
            mul_req_o.b = GOLDEN_Q64;
            mul_req_o.full_shift = 1'b1;
          end
          CS_ST_TOL: begin
            // Rounding (tol - 1) * floor(2^64 / 3) / 2^64 gives floor(tol / 3) exactly.
            mul_req_o.a = fix_t'({1'b0, tol_i}) - 64'sd1;
            mul_req_o.b = THIRD_Q64;
            mul_req_o.full_shift = 1'b1;
          end
          CS_PA_R: begin
            mul_req_o.a = ssub(x_q, w_q);
            mul_req_o.b = ssub(fx_q, fv_q);
          end
          CS_PA_Q: begin
            mul_req_o.a = ssub(x_q, v_q);
            mul_req_o.b = ssub(fx_q, fw_q);
          end
          CS_PA_T1: begin
            mul_req_o.a = ssub(x_q, v_q);
            mul_req_o.b = q_q;
          end
          CS_PA_T2: begin
            mul_req_o.a = ssub(x_q, w_q);
            mul_req_o.b = r_q;
          end
          CS_CK_QR: begin
            mul_req_o.a = q_q;
            mul_req_o.b = r_q;
          end
          CS_CK_QA: begin
            mul_req_o.a = q_q;
            mul_req_o.b = ssub(a_q, x_q);
          end
          CS_CK_QB: begin
            mul_req_o.a = q_q;
            mul_req_o.b = ssub(b_q, x_q);
          end
          default: begin
            mul_req_o.a = e_q;
            mul_req_o.b = GOLDEN_Q64;
            mul_req_o.full_shift = 1'b1;
          end
        endcase
        issued_d = 1'b1;
        if (issued_q && mul_rsp_i.done) begin
          issued_d = 1'b0;
          case (st_q)
            CS_ST_MUL: st_d = CS_ST_ADD;
            CS_ST_TOL: st_d = CS_OUT;
            CS_PA_R:   st_d = CS_PA_Q;
            CS_PA_Q:   st_d = CS_PA_T1;
            CS_PA_T1:  st_d = CS_PA_T2;
            CS_PA_T2:  st_d = CS_PA_PQ;
            CS_CK_QR:  st_d = CS_CK_QR_CMP;
            CS_CK_QA:  st_d = (p_q <= mul_rsp_i.value) ? CS_GOLD_E : CS_CK_QB;
            CS_CK_QB:  st_d = (p_q >= mul_rsp_i.value) ? CS_GOLD_E : CS_DIV;
            default:   st_d = CS_FINAL;
          endcase
        end
      end
      CS_ST_ADD: st_d = CS_ST_TOL;
      CS_DIV: begin
        div_req_o.start = !issued_q;
        div_req_o.p     = p_q;
        div_req_o.q     = q_q;
        issued_d = 1'b1;
        if (issued_q && div_rsp_i.done) begin
          issued_d = 1'b0;
          st_d = CS_DIV_U;
        end
      end
      CS_UPDATE:    st_d = CS_IT_MID;
      CS_IT_MID:    st_d = CS_IT_T2;
      CS_IT_T2:     st_d = CS_IT_TEST;
      CS_IT_TEST: begin
        if (done_cond) begin
          st_d    = CS_OUT;
          phase_d = PH_IDLE;
        end else if (sabs(e_q) > tol1_q) begin
          st_d = CS_PA_R;
        end else begin
          st_d = CS_GOLD_E;
        end
      end
      CS_PA_PQ:     st_d = CS_PA_DBL;
      CS_PA_DBL:    st_d = CS_PA_SIGN;
      CS_PA_SIGN:   st_d = CS_PA_QCHK;
      CS_PA_QCHK:   st_d = (q_q <= 0) ? CS_GOLD_E : CS_CK_QR;
      CS_CK_QR_CMP: st_d = (sabs(p_q) >= sabs(tmp_q >>> 1)) ? CS_GOLD_E : CS_CK_QA;
      CS_DIV_U:     st_d = CS_DIV_CHK;
      CS_DIV_CHK:   st_d = CS_FINAL;
      CS_GOLD_E:    st_d = CS_GOLD_MUL;
      CS_FINAL: begin
        st_d    = CS_OUT;
        phase_d = PH_PROBE;
      end
      CS_OUT: begin
        if (res_ready_i) st_d = CS_IDLE;
      end
      default: st_d = CS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (st_q)
      CS_IDLE: begin
        if (take_i) begin
          fu_q <= item_i.function_value;
          if (item_i.mode == MODE_START) begin
            a_q     <= (lower_i > upper_i) ? upper_i : lower_i;
            b_q     <= (lower_i > upper_i) ? lower_i : upper_i;
            fx_q    <= '0;
            fw_q    <= '0;
            fv_q    <= '0;
            e_q     <= '0;
            dlast_q <= '0;
          end else if (phase_q == PH_FIRST) begin
            fx_q <= item_i.function_value;
            fw_q <= item_i.function_value;
            fv_q <= item_i.function_value;
          end else if (phase_q == PH_IDLE) begin
            res_status_q <= ST_IGNORED;
            res_point_q  <= '0;
          end
        end
      end
      CS_ST_MUL: if (mul_rsp_i.done) tmp_q <= mul_rsp_i.value;
      CS_ST_ADD: begin
        x_q          <= x_new;
        w_q          <= x_new;
        v_q          <= x_new;
        probe_q      <= x_new;
        res_status_q <= ST_PROBE;
        res_point_q  <= x_new;
      end
      CS_ST_TOL: if (mul_rsp_i.done) tol3_q <= mul_rsp_i.value;
      CS_UPDATE: begin
        if (fu_q <= fx_q) begin
          if (probe_q < x_q) b_q <= x_q;
          else               a_q <= x_q;
          v_q  <= w_q;
          w_q  <= x_q;
          x_q  <= probe_q;
          fv_q <= fw_q;
          fw_q <= fx_q;
          fx_q <= fu_q;
        end else begin
          if (probe_q < x_q) a_q <= probe_q;
          else               b_q <= probe_q;
          if (fu_q <= fw_q || w_q == x_q) begin
            v_q  <= w_q;
            fv_q <= fw_q;
            w_q  <= probe_q;
            fw_q <= fu_q;
          end else if (fu_q <= fv_q || v_q == x_q || v_q == w_q) begin
            v_q  <= probe_q;
            fv_q <= fu_q;
          end
        end
      end
      CS_IT_MID: begin
        xm_q   <= midpoint(a_q, b_q);
        tol1_q <= sadd(sabs(x_q) >>> EPS_SHIFT, tol3_q);
      end
      CS_IT_T2: begin
        t2_q  <= sadd(tol1_q, tol1_q);
        tmp_q <= sabs(ssub(x_q, xm_q));
        u_q   <= ssub(b_q, xm_q);
      end
      CS_IT_TEST: begin
        p_q <= '0;
        q_q <= '0;
        r_q <= '0;
        if (done_cond) begin
          res_status_q <= ST_DONE;
          res_point_q  <= x_q;
        end
      end
      CS_PA_R:  if (mul_rsp_i.done) r_q <= mul_rsp_i.value;
      CS_PA_Q:  if (mul_rsp_i.done) q_q <= mul_rsp_i.value;
      CS_PA_T1: if (mul_rsp_i.done) p_q <= mul_rsp_i.value;
      CS_PA_T2: if (mul_rsp_i.done) tmp_q <= mul_rsp_i.value;
      CS_PA_PQ: begin
        p_q <= ssub(p_q, tmp_q);
        q_q <= ssub(q_q, r_q);
      end
      CS_PA_DBL: q_q <= sadd(q_q, q_q);
      CS_PA_SIGN: begin
        if (q_q > 0) p_q <= sneg(p_q);
        else         q_q <= sneg(q_q);
        r_q <= e_q;
        e_q <= dlast_q;
      end
      CS_CK_QR: if (mul_rsp_i.done) tmp_q <= mul_rsp_i.value;
      CS_DIV:   if (div_rsp_i.done) d_q <= div_rsp_i.value;
      CS_DIV_U: u_q <= sadd(x_q, d_q);
      CS_DIV_CHK: begin
        if (near_edge) d_q <= (x_q >= xm_q) ? sneg(tol1_q) : tol1_q;
      end
      CS_GOLD_E: e_q <= (x_q < xm_q) ? ssub(b_q, x_q) : ssub(a_q, x_q);
      CS_GOLD_MUL: if (mul_rsp_i.done) d_q <= mul_rsp_i.value;
      CS_FINAL: begin
        dlast_q      <= d_q;
        probe_q      <= final_u;
        res_status_q <= ST_PROBE;
        res_point_q  <= final_u;
      end
      default: ;
    endcase
  end

  assign idle_o       = (st_q == CS_IDLE);
  assign res_valid_o  = (st_q == CS_OUT);
  assign res_o.status = res_status_q;
  assign res_o.point  = res_point_q;

  a_idle_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == CS_IDLE) |-> !issued_q)
    else $error("unit request outstanding while idle");

  a_mul_done_expected: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_rsp_i.done |-> issued_q)
    else $error("product returned with no request pending");

  a_div_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req_o.start |-> (div_req_o.q > 0))
    else $error("quotient started with nonpositive divisor");

  a_done_goes_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == CS_OUT && res_status_q == ST_DONE) |-> (phase_q == PH_IDLE))
    else $error("search reported done but phase not idle");

endmodule

### hdl/brent_minimizer.sv
// Brent minimizer, probe-and-answer form. The function itself is evaluated outside.
// Configure lower_bound (0x00), upper_bound (0x08) and tolerance (0x10) over the
// 64-bit APB port while no search request is in flight; writes are seen at the next start.
// Input requests: mode 0 starts a search and answers with the first probe point;
// mode 1 carries f at the last probe and answers with the next probe (status 0) or
// the minimizer (status 1). A mode 1 request with no search running answers status 2.
// Every request gives exactly one result. in_stall_o is high while a request is being
// worked on; the next request is taken once the result sits in the output register.
// A start runs two products on the shared multiplier: the first probe and tol/3 as a
// reciprocal product. A value request that ends the search uses neither unit, a golden
// step runs one product, and a parabolic step runs seven products through the single
// shared 32x32 multiplier and one pass of the one-bit-per-cycle divider.
// Reset returns to idle with the default interval [0, 1] and tolerance 2^-13.
// A stalled result holds in the output register and the engine waits behind it.
module brent_minimizer #(
  parameter int FRACTION_BITS = bm_pkg::FRACTION_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bm_pkg::in_item_t  in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bm_pkg::out_item_t out_item_o
);
  import bm_pkg::*;

  fix_t        lower_q, upper_q;
  logic [62:0] tol_q;
  logic        wr_en;

  logic      core_idle, take, res_valid, res_ready;
  out_item_t res, out_item_q;
  logic      out_valid_q;
  mul_req_t  mul_req;
  div_req_t  div_req;
  unit_rsp_t mul_rsp, div_rsp;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= 64'sh1_0000_0000;
      tol_q   <= 63'd524288;
    end else if (wr_en) begin
      case (paddr[4:3])
        REG_LOWER: lower_q <= fix_t'(pwdata);
        REG_UPPER: upper_q <= fix_t'(pwdata);
        REG_TOL:   tol_q   <= pwdata[62:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_LOWER: prdata = 64'(lower_q);
      REG_UPPER: prdata = 64'(upper_q);
      REG_TOL:   prdata = {1'b0, tol_q};
      default:   prdata = '0;
    endcase
  end

  assign in_stall_o = !core_idle;
  assign take       = in_valid_i && core_idle;
  assign res_ready  = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) out_item_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  bm_mul #(.FRACTION_BITS(FRACTION_BITS)) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  bm_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  bm_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .lower_i     (lower_q),
    .upper_i     (upper_q),
    .tol_i       (tol_q),
    .take_i      (take),
    .item_i      (in_item_i),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .mul_req_o   (mul_req),
    .mul_rsp_i   (mul_rsp),
    .div_req_o   (div_req),
    .div_rsp_i   (div_rsp)
  );

endmodule

### bench/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import bm_pkg::*;

  localparam int FB = 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [63:0] GOLDEN = 64'd7046029254386353130;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  in_item_t in_item_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  out_item_t out_item_o;

  brent_minimizer dut (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // Predictor copy of the engine.
  fix_t cfg_lo = 0, cfg_hi = 64'sd4294967296;
  logic [62:0] cfg_tol = 63'd524288;
  phase_e ph = PH_IDLE;
  fix_t brk_a, brk_b, xb, xs, xt, fb, fs, ft, step_e, step_d, probe, tol3;

  out_item_t pending_results[$];
  int errors = 0;
  int requests_sent = 0, results_seen = 0, done_count = 0, probe_count = 0;
  int idle_cycles = 0;
  bit stall_random = 1'b1;

  function automatic fix_t shr_floor(fix_t a, int s);
    return a >>> s;
  endfunction

  function automatic fix_t fix_mul(fix_t a, fix_t b, int sh);
    logic [127:0] prod;
    logic [127:0] m;
    logic neg;
    neg = a[63] != b[63];
    prod = {64'd0, mag(a)} * {64'd0, mag(b)};
    prod = prod + (128'd1 << (sh - 1));
    m = prod >> sh;
    return from_mag(neg, m[127:64] != 0, m[63:0]);
  endfunction

  function automatic fix_t fix_div(fix_t p, fix_t q);
    logic [127:0] num, quo;
    if (q <= 0) return 0;
    num = {64'd0, mag(p)} << FB;
    quo = num / {64'd0, q};
    return from_mag(p[63], quo[127:64] != 0, quo[63:0]);
  endfunction

  function automatic logic iterate_step(output fix_t pt);
    fix_t xm, tol1, t2, p, q, r, d, u;
    xm = midpoint(brk_a, brk_b);
    tol1 = sadd(shr_floor(sabs(xb), EPS_SHIFT), tol3);
    t2 = sadd(tol1, tol1);
    p = 0; q = 0; r = 0;
    if (sabs(ssub(xb, xm)) <= ssub(t2, ssub(brk_b, xm))) begin
      pt = xb;
      return 1'b1;
    end
    if (sabs(step_e) > tol1) begin
      r = fix_mul(ssub(xb, xs), ssub(fb, ft), FB);
      q = fix_mul(ssub(xb, xt), ssub(fb, fs), FB);
      p = ssub(fix_mul(ssub(xb, xt), q, FB), fix_mul(ssub(xb, xs), r, FB));
      q = ssub(q, r);
      q = sadd(q, q);
      if (q > 0) p = sneg(p);
      else q = sneg(q);
      r = step_e;
      step_e = step_d;
    end
    if (q <= 0 || sabs(p) >= sabs(fix_mul(q, r, FB) >>> 1) ||
        p <= fix_mul(q, ssub(brk_a, xb), FB) || p >= fix_mul(q, ssub(brk_b, xb), FB)) begin
      step_e = (xb < xm) ? ssub(brk_b, xb) : ssub(brk_a, xb);
      d = fix_mul(step_e, fix_t'(GOLDEN), 64);
    end else begin
      d = fix_div(p, q);
      u = sadd(xb, d);
      if (ssub(u, brk_a) < t2 || ssub(brk_b, u) < t2) d = (xb >= xm) ? sneg(tol1) : tol1;
    end
    step_d = d;
    if (sabs(d) >= tol1) u = sadd(xb, d);
    else if (d > 0) u = sadd(xb, tol1);
    else u = ssub(xb, tol1);
    probe = u;
    pt = u;
    return 1'b0;
  endfunction

  function automatic out_item_t predict_search(in_item_t it);
    out_item_t res;
    fix_t a, b, fu, u, x;
    logic fin;
    fu = it.function_value;
    res.point = 0;
    if (it.mode == MODE_START) begin
      a = cfg_lo; b = cfg_hi;
      if (a > b) begin a = cfg_hi; b = cfg_lo; end
      brk_a = a; brk_b = b;
      xb = sadd(a, fix_mul(ssub(b, a), fix_t'(GOLDEN), 64));
      xs = xb; xt = xb; probe = xb;
      fb = 0; fs = 0; ft = 0; step_d = 0; step_e = 0;
      tol3 = fix_t'({1'b0, cfg_tol} / 64'd3);
      ph = PH_FIRST;
      res.status = ST_PROBE;
      res.point = xb;
    end else if (ph == PH_IDLE) begin
      res.status = ST_IGNORED;
    end else begin
      if (ph == PH_FIRST) begin
        fb = fu; fs = fu; ft = fu;
      end else begin
        u = probe; x = xb;
        if (fu <= fb) begin
          if (u < x) brk_b = x; else brk_a = x;
          xt = xs; xs = x; xb = u;
          ft = fs; fs = fb; fb = fu;
        end else begin
          if (u < x) brk_a = u; else brk_b = u;
          if (fu <= fs || xs == x) begin
            xt = xs; ft = fs; xs = u; fs = fu;
          end else if (fu <= ft || xt == x || xt == xs) begin
            xt = u; ft = fu;
          end
        end
      end
      fin = iterate_step(res.point);
      res.status = fin ? ST_DONE : ST_PROBE;
      ph = fin ? PH_IDLE : PH_PROBE;
    end
    return res;
  endfunction

  // Valid stays high after an accepted request until the next request or a pause
  // lowers it, so that it is never assigned twice in one time step.
  task automatic send_request(logic mode, fix_t fv);
    in_item_t it;
    int gap;
    gap = $urandom_range(0, 17);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.mode = mode;
    it.function_value = fv;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pending_results.push_back(predict_search(it));
    requests_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(reg_idx_e idx, logic [63:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= 5'(8 * int'(idx)); pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    penable <= 1'b0;
    case (idx)
      REG_LOWER: cfg_lo = fix_t'(val);
      REG_UPPER: cfg_hi = fix_t'(val);
      default:   cfg_tol = val[62:0];
    endcase
  endtask

  task automatic set_search(fix_t lo, fix_t hi, logic [63:0] tol);
    drain_results();
    write_reg(REG_LOWER, lo);
    write_reg(REG_UPPER, hi);
    write_reg(REG_TOL, tol);
    psel <= 1'b0;
    pwrite <= 1'b0;
  endtask

  function automatic fix_t rand_fix();
    return fix_t'({$urandom, $urandom});
  endfunction

  // Smooth test function: f(x) = (x - c)^2 scaled; noisy runs use random values instead.
  function automatic fix_t bowl(fix_t x, fix_t c);
    fix_t dlt;
    dlt = ssub(x, c);
    return fix_mul(dlt, dlt, FB);
  endfunction

  // Runs one search to completion with a bowl-shaped function (random values when noisy), or breaks it off.
  task automatic run_search(fix_t c, int max_values, bit noisy);
    out_item_t last;
    fix_t pt, fv;
    send_request(MODE_START, 0);
    pt = pending_results[$].point;
    for (int i = 0; i < max_values; i++) begin
      fv = noisy ? rand_fix() : bowl(pt, c);
      send_request(MODE_VALUE, fv);
      last = pending_results[$];
      if (last.status != ST_PROBE) break;
      pt = last.point;
    end
  endtask

  task automatic test_directed();
    send_request(MODE_VALUE, FIX_MAX);
    send_request(MODE_VALUE, FIX_MIN);
    run_search(64'sd1 <<< 31, 12, 0);
    send_request(MODE_START, 0);
    send_request(MODE_START, 0);
    send_request(MODE_VALUE, FIX_MIN);
    send_request(MODE_VALUE, FIX_MAX);
    send_request(MODE_VALUE, 0);
    send_request(MODE_VALUE, -64'sd1);
  endtask

  task automatic test_reversed_and_extreme_bounds();
    set_search(64'sd5 <<< 32, -(64'sd3 <<< 32), 64'd1 << 20);
    run_search(64'sd1 <<< 32, 40, 0);
    set_search(FIX_MIN, FIX_MAX, 64'h7FFF_FFFF_FFFF_FFFF);
    run_search(0, 10, 0);
    run_search(0, 8, 1);
    set_search(FIX_MIN, FIX_MAX, 0);
    run_search(64'sd7 <<< 30, 30, 0);
    set_search(64'sd1 <<< 32, 64'sd1 <<< 32, 64'd524288);
    run_search(0, 4, 0);
  endtask

  task automatic test_zero_tolerance();
    set_search(-(64'sd2 <<< 32), 64'sd2 <<< 32, 0);
    run_search(64'sd3 <<< 29, 60, 0);
    send_request(MODE_VALUE, rand_fix());
  endtask

  task automatic test_random_searches();
    fix_t lo, hi, c;
    int span;
    while (requests_sent < 1750) begin
      span = $urandom_range(0, 9);
      if (span == 0) begin
        lo = rand_fix(); hi = rand_fix();
      end else begin
        lo = fix_t'($signed($urandom_range(0, 64)) - 32) <<< (20 + $urandom_range(0, 14));
        hi = lo + (fix_t'($urandom_range(1, 4096)) <<< (16 + $urandom_range(0, 16)));
        if ($urandom_range(0, 3) == 0) begin c = lo; lo = hi; hi = c; end
      end
      set_search(lo, hi, $urandom_range(0, 3) == 0 ? {$urandom, $urandom}
                                                  : 64'($urandom_range(0, 1 << 24)));
      stall_random = $urandom_range(0, 3) != 0;
      for (int k = 0; k < 4; k++) begin
        c = midpoint(lo, hi) + (fix_t'($signed($urandom)) <<< $urandom_range(0, 8));
        case ($urandom_range(0, 9))
          0: run_search(c, 6, 1);
          1: run_search(c, $urandom_range(1, 5), 0);
          2: send_request(MODE_VALUE, rand_fix());
          default: run_search(c, 60, 0);
        endcase
        if ($urandom_range(0, 15) == 0) drain_results();
      end
    end
  endtask

  // Result side: random stall and compare against the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_res;
    if (out_valid_o && !out_stall_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%t: unexpected result status %0d point %h", $realtime,
                 out_item_o.status, out_item_o.point);
      end else begin
        exp_res = pending_results.pop_front();
        if (out_item_o.status != exp_res.status) begin
          errors++;
          $display("%t: status expected %0d actual %0d", $realtime,
                   exp_res.status, out_item_o.status);
        end
        if (out_item_o.point != exp_res.point) begin
          errors++;
          $display("%t: point expected %h actual %h", $realtime,
                   exp_res.point, out_item_o.point);
        end
        if (exp_res.status == ST_DONE) done_count++;
        else if (exp_res.status == ST_PROBE) probe_count++;
      end
    end
    if (rst_ni) out_stall_i <= stall_random ? ($urandom_range(0, 17) > 12) : 1'b0;
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_reversed_and_extreme_bounds();
    test_zero_tolerance();
    test_random_searches();
    drain_results();
    $display("Sent %0d requests; %0d results: %0d probes, %0d finished searches.",
             requests_sent, results_seen, probe_count, done_count);
    $display("Covered reversed, extreme and degenerate intervals, zero tolerance and idle values.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
